@@ rtl/core/itc_pkg.sv @@
`timescale 1ns / 1ps
// IPv6 text compressor: shared types, constants and helpers.
// No dependencies; every other file imports this package.
package itc_pkg;

    localparam int ADDR_HALF_W = 64;
    localparam int GROUP_W     = 16;
    localparam int NUM_GROUPS  = 8;
    localparam int NIB_W       = 4;
    localparam int CHAR_W      = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int DEC_DIGITS  = 10;

    localparam int GRP_IDX_W   = $clog2(NUM_GROUPS);
    localparam int GRP_CNT_W   = GRP_IDX_W + 1;
    localparam int NIBS        = GROUP_W / NIB_W;
    localparam int NIB_IDX_W   = $clog2(NIBS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3a;

    typedef logic [GROUP_W-1:0]            t_group;
    typedef logic [0:NUM_GROUPS-1][GROUP_W-1:0] t_groups;
    typedef logic [GRP_IDX_W-1:0]          t_grp_idx;
    typedef logic [GRP_CNT_W-1:0]          t_grp_cnt;
    typedef logic [NIB_IDX_W-1:0]          t_nib_idx;

    // One classified address: groups plus the zero run chosen for "::".
    typedef struct packed {
        t_groups  grp;
        logic     have_run;
        t_grp_idx run_start;
        t_grp_cnt run_end;     // first group after the run, NUM_GROUPS at the end
    } t_item;

endpackage

@@ rtl/core/itc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for addresses in and characters out.
// Depends on itc_pkg.
interface itc_in_if import itc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ADDR_HALF_W-1:0] addr_high;
    logic [ADDR_HALF_W-1:0] addr_low;

    modport source (output valid, output addr_high, output addr_low, input ready);
    modport sink   (input valid, input addr_high, input addr_low, output ready);
endinterface

interface itc_out_if import itc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ rtl/core/ipv6_text_compressor.sv @@
`timescale 1ns / 1ps
// IPv6 address to compressed text, one ASCII character beat per cycle while o_out is ready.
// The first character passes through the front register, the queue and the output register.
// Throughput: one character per cycle while o_out is ready and an address is queued; an
// address spells out 2 to 39 characters, set by the back-end character sequencer.
// Reset: synchronous active-low i_rst_n empties the front stage, queue and output register.
module ipv6_text_compressor import itc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itc_in_if.sink     i_in,
    itc_out_if.source  o_out
);

    // front -> queue
    logic  front_valid;
    t_item front_item;
    logic  q_full;

    // queue -> back
    logic  q_valid;
    t_item q_head;
    logic  q_pop;

    // Front: best zero run is found in the cycle the beat arrives, then registered.
    itc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (!q_full)
    );

    // Queue decouples classification from the per-character walk, so the front
    // can take the next address while the back end is still spelling one out.
    itc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .i_push_item (front_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    // Back: walks groups, digits, separators and the "::" run; pops when the
    // character that carries is_last is loaded into the output register.
    itc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

@@ rtl/core/itc_front.sv @@
`timescale 1ns / 1ps
// Front end: takes an address beat, finds the best zero run, registers it.
// Depends on itc_pkg and itc_if.
module itc_front import itc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    itc_in_if.sink i_in,
    output logic   o_valid,
    output t_item  o_item,
    input  logic   i_ready
);

    logic                  r_valid;
    t_item                 r_item;
    t_item                 n_item;
    t_groups               grp;
    logic [NUM_GROUPS-1:0] z;
    logic [NUM_GROUPS-1:0] prev_nz;
    t_grp_cnt              rl [0:NUM_GROUPS];
    t_grp_cnt              run_end_s;
    logic [GRP_CNT_W:0]    score;
    logic [GRP_CNT_W:0]    best_score;
    logic                  touch;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_comb begin
        grp = {i_in.addr_high, i_in.addr_low};
        for (int k = 0; k < NUM_GROUPS; k++) begin
            z[k] = (grp[k] == '0);
        end
        // prev_nz[k]: group k-1 is nonzero, or k is the first group
        prev_nz = {~z[NUM_GROUPS-2:0], 1'b1};

        rl[NUM_GROUPS] = '0;
        for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
            rl[k] = z[k] ? rl[k+1] + t_grp_cnt'(1) : '0;
        end

        n_item.grp       = grp;
        n_item.have_run  = 1'b0;
        n_item.run_start = '0;
        n_item.run_end   = '0;
        best_score       = '0;
        run_end_s        = '0;
        score            = '0;
        touch            = 1'b0;
        // later runs win ties
        for (int s = 0; s < NUM_GROUPS; s++) begin
            run_end_s = t_grp_cnt'(s) + rl[s];
            touch     = (s == 0) || (run_end_s == t_grp_cnt'(NUM_GROUPS));
            score     = {rl[s], 1'b0} - (touch ? (GRP_CNT_W+1)'(2) : (GRP_CNT_W+1)'(1));
            if (z[s] && prev_nz[s] && (rl[s] >= t_grp_cnt'(2)) && (score >= best_score)) begin
                best_score       = score;
                n_item.have_run  = 1'b1;
                n_item.run_start = t_grp_idx'(s);
                n_item.run_end   = run_end_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

endmodule

@@ rtl/core/itc_fifo.sv @@
`timescale 1ns / 1ps
// Short queue of classified addresses between front and back end.
// Depends on itc_pkg.
module itc_fifo import itc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ rtl/core/itc_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the queue head one character per cycle, while the output is ready, into an output register.
// Depends on itc_pkg and itc_if.
module itc_back import itc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_pop,
    itc_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_ENTER,    // about to start group r_grp
        S_GROUP,    // hex digits of group r_grp
        S_SEP,      // ':' after group r_grp
        S_RUN1,     // first ':' of the compressed run
        S_RUN2      // second ':' when the run starts at group zero
    } t_state;

    t_state                  r_state, n_state, eff_state;
    t_grp_idx                r_grp, n_grp;
    t_nib_idx                r_nib, n_nib, eff_nib;
    logic                    r_out_valid;
    logic [CHAR_W-1:0]       r_char, n_char;
    logic                    r_last, n_last;
    logic                    adv;
    logic                    fire;
    t_group                  cur;
    logic [NIBS-1:0][NIB_W-1:0] cur_nibs;
    logic [NIB_W-1:0]        nib;
    logic                    at_end;

    function automatic t_nib_idx lead_nib(input t_group v);
        logic [NIBS-1:0][NIB_W-1:0] n;
        t_nib_idx                   idx;
        n   = v;
        idx = t_nib_idx'(NIBS - 1);
        for (int k = 0; k < NIBS; k++) begin
            if (n[k] != '0) begin
                idx = t_nib_idx'(NIBS - 1 - k);
            end
        end
        return idx;
    endfunction

    assign adv          = !r_out_valid || o_out.ready;
    assign fire         = adv && i_valid;
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.is_last   = r_last;

    always_comb begin
        cur      = i_item.grp[r_grp];
        cur_nibs = cur;
        at_end   = (i_item.run_end == t_grp_cnt'(NUM_GROUPS));

        eff_state = r_state;
        eff_nib   = r_nib;
        if (r_state == S_ENTER) begin
            if (i_item.have_run && (r_grp == i_item.run_start)) begin
                eff_state = S_RUN1;
            end else begin
                eff_state = S_GROUP;
                eff_nib   = lead_nib(cur);
            end
        end

        nib = cur_nibs[~eff_nib];

        n_state = r_state;
        n_grp   = r_grp;
        n_nib   = r_nib;
        n_char  = CHAR_COLON;
        n_last  = 1'b0;
        case (eff_state)
            S_GROUP: begin
                n_char = (nib < NIB_W'(DEC_DIGITS)) ? CHAR_ZERO + CHAR_W'(nib)
                                                    : CHAR_A + CHAR_W'(nib) - CHAR_W'(DEC_DIGITS);
                if (eff_nib == t_nib_idx'(NIBS - 1)) begin
                    if (r_grp == t_grp_idx'(NUM_GROUPS - 1)) begin
                        n_last = 1'b1;
                    end else begin
                        n_state = S_SEP;
                    end
                end else begin
                    n_state = S_GROUP;
                    n_nib   = eff_nib + t_nib_idx'(1);
                end
            end
            S_SEP: begin
                n_state = S_ENTER;
                n_grp   = r_grp + t_grp_idx'(1);
            end
            S_RUN1: begin
                if (i_item.run_start == '0) begin
                    n_state = S_RUN2;
                end else if (at_end) begin
                    n_last = 1'b1;
                end else begin
                    n_state = S_ENTER;
                    n_grp   = i_item.run_end[GRP_IDX_W-1:0];
                end
            end
            S_RUN2: begin
                if (at_end) begin
                    n_last = 1'b1;
                end else begin
                    n_state = S_ENTER;
                    n_grp   = i_item.run_end[GRP_IDX_W-1:0];
                end
            end
            default: begin
                n_state = S_ENTER;
            end
        endcase

        // last character: next address starts fresh
        if (n_last) begin
            n_state = S_ENTER;
            n_grp   = '0;
        end
    end

    assign o_pop = fire && n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ENTER;
            r_grp       <= '0;
            r_nib       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_state <= n_state;
                r_grp   <= n_grp;
                r_nib   <= n_nib;
            end
            if (adv) begin
                r_out_valid <= i_valid;
            end
        end
        if (fire) begin
            r_char <= n_char;
            r_last <= n_last;
        end
    end

endmodule
